// ----- design/http_request_head_parser_defines.svh -----
// Assertion macros for the HTTP request head parser.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef HTTP_REQUEST_HEAD_PARSER_DEFINES_SVH
`define HTTP_REQUEST_HEAD_PARSER_DEFINES_SVH

// same-cycle implication
`define HRHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HRHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/hrhp_pkg.sv -----
// Package for the HTTP request head parser: status codes, character codes,
// keyword tables and small byte compare helpers. No dependencies.
package hrhp_pkg;

  localparam int URL_DEPTH_DEFAULT = 128;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_C  = 8'h63;
  localparam logic [7:0] CH_K  = 8'h6B;

  localparam logic [3:0] LEN_GET   = 4'd4;
  localparam logic [3:0] LEN_HEAD  = 4'd5;
  localparam logic [3:0] LEN_VER   = 4'd11;
  localparam logic [3:0] LEN_CONN  = 4'd11;
  localparam logic [3:0] LEN_CLOSE = 4'd5;
  localparam logic [3:0] LEN_KEEP  = 4'd10;

  function automatic logic [7:0] get_char(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0: c = "G";
      4'd1: c = "E";
      4'd2: c = "T";
      4'd3: c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] head_char(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0: c = "H";
      4'd1: c = "E";
      4'd2: c = "A";
      4'd3: c = "D";
      4'd4: c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ver_char(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0: c = " ";
      4'd1: c = "H";
      4'd2: c = "T";
      4'd3: c = "T";
      4'd4: c = "P";
      4'd5: c = "/";
      4'd6: c = "1";
      4'd7: c = ".";
      4'd8: c = "1";
      4'd9: c = CH_CR;
      4'd10: c = CH_LF;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] conn_char(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0: c = "c";
      4'd1: c = "o";
      4'd2: c = "n";
      4'd3: c = "n";
      4'd4: c = "e";
      4'd5: c = "c";
      4'd6: c = "t";
      4'd7: c = "i";
      4'd8: c = "o";
      4'd9: c = "n";
      4'd10: c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] close_char(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0: c = "c";
      4'd1: c = "l";
      4'd2: c = "o";
      4'd3: c = "s";
      4'd4: c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] keep_char(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0: c = "k";
      4'd1: c = "e";
      4'd2: c = "e";
      4'd3: c = "p";
      4'd4: c = "-";
      4'd5: c = "a";
      4'd6: c = "l";
      4'd7: c = "i";
      4'd8: c = "v";
      4'd9: c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // upper case ASCII folds to lower case; nothing else folds
  function automatic logic ci_eq(input logic [7:0] c, input logic [7:0] s);
    return (c == s) || (c >= "A" && c <= "Z" && (c + 8'd32) == s);
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_HT);
  endfunction

endpackage

// ----- design/http_request_head_parser.sv -----
// HTTP/1.1 request head parser, one request byte per word.
// Depends on hrhp_pkg and http_request_head_parser_defines.svh.
//
//  channel  | dir | payload (low bit first)
//  s_axis   | in  | tdata: data_byte[7:0]
//  m_axis   | out | tdata: status[1:0], method, url_length[6:0], url_char[7:0],
//           |     |        conn_close, zero pad; tuser: url_char_valid
//
// One result word per input word; one per cycle while m_axis_tready is high.
// Path: an input register, then the parse step into the result register.
// The input register accepts one more word while a result waits on m_axis_tready.
// Reset is synchronous; it empties both registers and returns the parser to
// method matching. A head that completes or fails restarts the parser.
`include "http_request_head_parser_defines.svh"

module http_request_head_parser
  import hrhp_pkg::*;
#(
  parameter int URL_DEPTH = URL_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // status[1:0], method, url_length[6:0],
                                      // url_char[7:0], conn_close, pad
  output logic [0:0]  m_axis_tuser    // url_char_valid
);

  localparam int CW = $clog2(URL_DEPTH);
  localparam logic [CW-1:0] URL_LAST = CW'(URL_DEPTH - 1);

  typedef enum logic [3:0] {
    PH_METHOD, PH_URL, PH_VERSION, PH_LINE, PH_NAME, PH_SKIP, PH_SKIP_LF,
    PH_SKIP_FOLD, PH_LWS1, PH_LWS1_LF, PH_LWS1_FOLD, PH_VALUE, PH_LWS2,
    PH_LWS2_LF, PH_LWS2_FOLD, PH_END_LF
  } phase_t;

  typedef struct packed {
    phase_t     ph;
    logic [3:0] pos;
  } step_t;

  function automatic step_t name_step(input logic [7:0] b, input logic [3:0] p);
    step_t r;
    if (p < LEN_CONN && ci_eq(b, conn_char(p))) begin
      if (p == LEN_CONN - 4'd1) begin
        r.ph  = PH_LWS1;
        r.pos = 4'd0;
      end else begin
        r.ph  = PH_NAME;
        r.pos = p + 4'd1;
      end
    end else begin
      r.pos = 4'd0;
      r.ph  = (b == CH_CR) ? PH_SKIP_LF : PH_SKIP;
    end
    return r;
  endfunction

  function automatic step_t line_start(input logic [7:0] b);
    step_t r;
    if (b == CH_CR) begin
      r.ph  = PH_END_LF;
      r.pos = 4'd0;
    end else begin
      r = name_step(b, 4'd0);
    end
    return r;
  endfunction

  logic          in_valid;
  logic [7:0]    in_byte;
  logic          advance;

  phase_t        phase, phase_next;
  logic [3:0]    match_pos, match_pos_next;
  logic [1:0]    mask, mask_next;
  logic [CW-1:0] url_count, url_count_next;
  logic          method_seen, method_seen_next;
  logic          close_seen, close_seen_next;
  logic [1:0]    status_next;
  logic [7:0]    echo_next;
  logic          echo_valid_next;

  logic [1:0]    out_status;
  logic          out_method;
  logic [6:0]    out_len;
  logic [7:0]    out_char;
  logic          out_char_valid;
  logic          out_close;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_comb begin
    logic [7:0] b;
    logic [3:0] p;
    logic [1:0] m;
    logic [3:0] vlen;
    logic [7:0] vch;
    step_t      st;
    b = in_byte;
    p = match_pos;
    m = mask;
    vlen = mask[0] ? LEN_CLOSE : LEN_KEEP;
    vch  = mask[0] ? close_char(p) : keep_char(p);
    st = line_start(b);
    phase_next       = phase;
    match_pos_next   = match_pos;
    mask_next        = mask;
    url_count_next   = url_count;
    method_seen_next = method_seen;
    close_seen_next  = close_seen;
    status_next      = ST_BUSY;
    echo_next        = 8'h00;
    echo_valid_next  = 1'b0;
    unique case (phase)
      PH_METHOD: begin
        if (m[0] && !(p < LEN_GET && b == get_char(p))) m[0] = 1'b0;
        if (m[1] && !(p < LEN_HEAD && b == head_char(p))) m[1] = 1'b0;
        mask_next = m;
        if (m == 2'b00) begin
          status_next = ST_ERR;
        end else if (m[0] && p == LEN_GET - 4'd1) begin
          method_seen_next = 1'b0;
          phase_next       = PH_URL;
          match_pos_next   = 4'd0;
        end else if (m[1] && p == LEN_HEAD - 4'd1) begin
          method_seen_next = 1'b1;
          phase_next       = PH_URL;
          match_pos_next   = 4'd0;
        end else begin
          match_pos_next = p + 4'd1;
        end
      end
      PH_URL: begin
        if (b == CH_SP) begin
          phase_next     = PH_VERSION;
          match_pos_next = 4'd1;
        end else if (url_count >= URL_LAST) begin
          status_next = ST_ERR;
        end else begin
          url_count_next  = url_count + CW'(1);
          echo_next       = b;
          echo_valid_next = 1'b1;
        end
      end
      PH_VERSION: begin
        if (p < LEN_VER && b == ver_char(p)) begin
          if (p == LEN_VER - 4'd1) begin
            phase_next     = PH_LINE;
            match_pos_next = 4'd0;
          end else begin
            match_pos_next = p + 4'd1;
          end
        end else begin
          status_next = ST_ERR;
        end
      end
      PH_LINE: begin
        phase_next     = st.ph;
        match_pos_next = st.pos;
      end
      PH_NAME: begin
        st             = name_step(b, p);
        phase_next     = st.ph;
        match_pos_next = st.pos;
      end
      PH_SKIP: begin
        if (b == CH_CR) phase_next = PH_SKIP_LF;
      end
      PH_SKIP_LF: begin
        if (b == CH_LF) phase_next = PH_SKIP_FOLD;
        else status_next = ST_ERR;
      end
      PH_SKIP_FOLD: begin
        if (is_ws(b)) begin
          phase_next = PH_SKIP;
        end else begin
          phase_next     = st.ph;
          match_pos_next = st.pos;
        end
      end
      PH_LWS1: begin
        priority if (is_ws(b)) begin
        end else if (b == CH_CR) begin
          phase_next = PH_LWS1_LF;
        end else if (ci_eq(b, CH_C)) begin
          mask_next      = 2'b01;
          match_pos_next = 4'd1;
          phase_next     = PH_VALUE;
        end else if (ci_eq(b, CH_K)) begin
          mask_next      = 2'b10;
          match_pos_next = 4'd1;
          phase_next     = PH_VALUE;
        end else begin
          status_next = ST_ERR;
        end
      end
      PH_LWS1_LF: begin
        if (b == CH_LF) phase_next = PH_LWS1_FOLD;
        else status_next = ST_ERR;
      end
      PH_LWS1_FOLD: begin
        if (is_ws(b)) phase_next = PH_LWS1;
        else status_next = ST_ERR;
      end
      PH_VALUE: begin
        if (p < vlen && ci_eq(b, vch)) begin
          match_pos_next = p + 4'd1;
          if (p + 4'd1 == vlen) phase_next = PH_LWS2;
        end else begin
          status_next = ST_ERR;
        end
      end
      PH_LWS2: begin
        if (b == CH_CR) phase_next = PH_LWS2_LF;
        else if (!is_ws(b)) status_next = ST_ERR;
      end
      PH_LWS2_LF: begin
        if (b == CH_LF) phase_next = PH_LWS2_FOLD;
        else status_next = ST_ERR;
      end
      PH_LWS2_FOLD: begin
        if (is_ws(b)) begin
          phase_next = PH_LWS2;
        end else begin
          close_seen_next = mask[0];
          phase_next      = st.ph;
          match_pos_next  = st.pos;
        end
      end
      PH_END_LF: begin
        status_next = (b == CH_LF) ? ST_DONE : ST_ERR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      phase         <= PH_METHOD;
      match_pos     <= 4'd0;
      mask          <= 2'b11;
      url_count     <= '0;
      method_seen   <= 1'b0;
      close_seen    <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) in_valid <= 1'b1;
      else if (advance) in_valid <= 1'b0;
      if (advance) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (advance) begin
        if (status_next != ST_BUSY) begin
          phase       <= PH_METHOD;
          match_pos   <= 4'd0;
          mask        <= 2'b11;
          url_count   <= '0;
          method_seen <= 1'b0;
          close_seen  <= 1'b0;
        end else begin
          phase       <= phase_next;
          match_pos   <= match_pos_next;
          mask        <= mask_next;
          url_count   <= url_count_next;
          method_seen <= method_seen_next;
          close_seen  <= close_seen_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) in_byte <= s_axis_tdata;
    if (advance) begin
      out_status     <= status_next;
      out_method     <= method_seen_next;
      out_len        <= 7'(url_count_next);
      out_char       <= echo_next;
      out_char_valid <= echo_valid_next;
      out_close      <= close_seen_next;
    end
  end

  assign m_axis_tdata = {5'd0, out_close, out_char, out_len, out_method, out_status};
  assign m_axis_tuser = out_char_valid;

  `HRHP_ASSERT_NOW(a_echo_busy, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[1:0] == ST_BUSY, "URL byte echoed on a finishing word")
  `HRHP_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3, "undefined status code")
  `HRHP_ASSERT_NEXT(a_restart, advance && status_next != ST_BUSY, phase == PH_METHOD && url_count == '0 && mask == 2'b11, "parser did not restart")
  `HRHP_ASSERT_NEXT(a_in_hold, in_valid && !advance, in_valid && $stable(in_byte), "input word lost while stalled")

endmodule

// ----- verif/tb_http_request_head_parser.sv -----
// Testbench for http_request_head_parser: streams request bytes, predicts every result word
// with its own parser model and checks each output field. Depends on hrhp_pkg and the RTL.
`timescale 1ns / 100ps

module tb_http_request_head_parser;
  import hrhp_pkg::*;

  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 60;

  localparam logic [87:0] KW_GET   = 88'("GET ");
  localparam logic [87:0] KW_HEAD  = 88'("HEAD ");
  localparam logic [87:0] KW_VER   = 88'(" HTTP/1.1\r\n");
  localparam logic [87:0] KW_CONN  = 88'("connection:");
  localparam logic [87:0] KW_CLOSE = 88'("close");
  localparam logic [87:0] KW_KEEP  = 88'("keep-alive");

  typedef enum logic [3:0] {
    P_METHOD, P_URL, P_VERSION, P_LINE, P_NAME, P_SKIP, P_SKIP_LF, P_SKIP_FOLD,
    P_LWS1, P_LWS1_LF, P_LWS1_FOLD, P_VALUE, P_LWS2, P_LWS2_LF, P_LWS2_FOLD, P_END_LF
  } parse_phase_t;

  typedef struct packed {
    logic [1:0] status;
    logic       method;
    logic [6:0] url_length;
    logic [7:0] url_char;
    logic       url_char_valid;
    logic       conn_close;
  } head_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  http_request_head_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // parser model state
  parse_phase_t hp_phase = P_METHOD;
  int           hp_pos = 0;
  logic [1:0]   hp_cand = 2'b11;
  int           hp_url_cnt = 0;
  logic         hp_is_head = 1'b0;
  logic         hp_close = 1'b0;

  head_result_t head_results_q[$];
  head_result_t exp_word;
  logic [7:0]   req_bytes[$];
  int           errors = 0;
  int           burst_left = 0;
  logic         steady_send = 1'b0;
  int           idle_cycles = 0;

  int hold_req_cnt = 0;
  int hold_ack_cnt = 0;
  int hold_left = 0;
  int stretch_left = 0;
  int stretch_mode = 0;
  int stretch_ctr = 0;

  function automatic logic [7:0] kw_at(input logic [87:0] kw, input int len, input int i);
    return kw[8*(len-1-i) +: 8];
  endfunction

  function automatic logic fold_eq(input logic [7:0] c, input logic [7:0] s);
    return (c == s) || (c >= "A" && c <= "Z" && 8'(c + 8'd32) == s);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_HT);
  endfunction

  function automatic void match_name(input logic [7:0] b);
    int p;
    p = hp_pos;
    if (p < 11 && fold_eq(b, kw_at(KW_CONN, 11, p))) begin
      if (p == 10) begin
        hp_phase = P_LWS1;
        hp_pos = 0;
      end else begin
        hp_phase = P_NAME;
        hp_pos = p + 1;
      end
    end else begin
      hp_pos = 0;
      hp_phase = (b == CH_CR) ? P_SKIP_LF : P_SKIP;
    end
  endfunction

  function automatic void start_line(input logic [7:0] b);
    hp_pos = 0;
    if (b == CH_CR) hp_phase = P_END_LF;
    else match_name(b);
  endfunction

  function automatic head_result_t parse_byte(input logic [7:0] b);
    head_result_t r;
    logic [1:0]   st;
    logic [1:0]   m;
    logic [87:0]  vkw;
    int           vlen;
    int           p;
    r = '0;
    st = ST_BUSY;
    p = hp_pos;
    case (hp_phase)
      P_METHOD: begin
        m = hp_cand;
        if (m[0] && !(p < 4 && b == kw_at(KW_GET, 4, p))) m[0] = 1'b0;
        if (m[1] && !(p < 5 && b == kw_at(KW_HEAD, 5, p))) m[1] = 1'b0;
        hp_cand = m;
        if (m == 2'b00) begin
          st = ST_ERR;
        end else if (m[0] && p == 3) begin
          hp_is_head = 1'b0;
          hp_phase = P_URL;
          hp_pos = 0;
        end else if (m[1] && p == 4) begin
          hp_is_head = 1'b1;
          hp_phase = P_URL;
          hp_pos = 0;
        end else begin
          hp_pos = p + 1;
        end
      end
      P_URL: begin
        if (b == CH_SP) begin
          hp_phase = P_VERSION;
          hp_pos = 1;
        end else if (hp_url_cnt + 1 >= URL_DEPTH_DEFAULT) begin
          st = ST_ERR;
        end else begin
          hp_url_cnt++;
          r.url_char = b;
          r.url_char_valid = 1'b1;
        end
      end
      P_VERSION: begin
        if (p < 11 && b == kw_at(KW_VER, 11, p)) begin
          if (p == 10) begin
            hp_phase = P_LINE;
            hp_pos = 0;
          end else begin
            hp_pos = p + 1;
          end
        end else begin
          st = ST_ERR;
        end
      end
      P_LINE: start_line(b);
      P_NAME: match_name(b);
      P_SKIP: if (b == CH_CR) hp_phase = P_SKIP_LF;
      P_SKIP_LF: begin
        if (b == CH_LF) hp_phase = P_SKIP_FOLD;
        else st = ST_ERR;
      end
      P_SKIP_FOLD: begin
        if (is_blank(b)) hp_phase = P_SKIP;
        else start_line(b);
      end
      P_LWS1: begin
        if (is_blank(b)) begin
        end else if (b == CH_CR) begin
          hp_phase = P_LWS1_LF;
        end else if (fold_eq(b, CH_C)) begin
          hp_cand = 2'b01;
          hp_pos = 1;
          hp_phase = P_VALUE;
        end else if (fold_eq(b, CH_K)) begin
          hp_cand = 2'b10;
          hp_pos = 1;
          hp_phase = P_VALUE;
        end else begin
          st = ST_ERR;
        end
      end
      P_LWS1_LF: begin
        if (b == CH_LF) hp_phase = P_LWS1_FOLD;
        else st = ST_ERR;
      end
      P_LWS1_FOLD: begin
        if (is_blank(b)) hp_phase = P_LWS1;
        else st = ST_ERR;
      end
      P_VALUE: begin
        if (hp_cand[0]) begin
          vkw = KW_CLOSE;
          vlen = 5;
        end else begin
          vkw = KW_KEEP;
          vlen = 10;
        end
        if (p < vlen && fold_eq(b, kw_at(vkw, vlen, p))) begin
          hp_pos = p + 1;
          if (hp_pos == vlen) hp_phase = P_LWS2;
        end else begin
          st = ST_ERR;
        end
      end
      P_LWS2: begin
        if (b == CH_CR) hp_phase = P_LWS2_LF;
        else if (!is_blank(b)) st = ST_ERR;
      end
      P_LWS2_LF: begin
        if (b == CH_LF) hp_phase = P_LWS2_FOLD;
        else st = ST_ERR;
      end
      P_LWS2_FOLD: begin
        if (is_blank(b)) begin
          hp_phase = P_LWS2;
        end else begin
          hp_close = hp_cand[0];
          start_line(b);
        end
      end
      default: st = (b == CH_LF) ? ST_DONE : ST_ERR;
    endcase
    r.status = st;
    r.method = hp_is_head;
    r.url_length = hp_url_cnt[6:0];
    r.conn_close = hp_close;
    if (st != ST_BUSY) begin
      hp_phase = P_METHOD;
      hp_pos = 0;
      hp_cand = 2'b11;
      hp_url_cnt = 0;
      hp_is_head = 1'b0;
      hp_close = 1'b0;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int exp, input int act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (head_results_q.size() == 0) begin
        $error("result word with nothing expected: tdata %h", m_axis_tdata);
        errors++;
      end else begin
        exp_word = head_results_q.pop_front();
        check_field("status", exp_word.status, m_axis_tdata[1:0]);
        check_field("method", exp_word.method, m_axis_tdata[2]);
        check_field("url_length", exp_word.url_length, m_axis_tdata[9:3]);
        check_field("url_char", exp_word.url_char, m_axis_tdata[17:10]);
        check_field("url_char_valid", exp_word.url_char_valid, m_axis_tuser[0]);
        check_field("conn_close", exp_word.conn_close, m_axis_tdata[18]);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (stretch_left == 0) begin
        stretch_left <= $urandom_range(16, 96);
        stretch_mode <= $urandom_range(0, 2);
      end else begin
        stretch_left <= stretch_left - 1;
      end
      case (stretch_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 9) < 7);
        default: m_axis_tready <= (stretch_ctr % 4 == 0);
      endcase
      stretch_ctr <= stretch_ctr + 1;
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0 || steady_send) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    head_results_q.push_back(parse_byte(b));
  endtask

  task automatic flush_request();
    foreach (req_bytes[i]) send_byte(req_bytes[i]);
    req_bytes.delete();
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (head_results_q.size() != 0);
  endtask

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endfunction

  // raise lower-case letters at random
  function automatic void put_mixed(input string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
      req_bytes.push_back(c);
    end
  endfunction

  function automatic logic [7:0] url_octet();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_SP);
    return c;
  endfunction

  function automatic void put_lws();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 2))
        0: req_bytes.push_back(CH_SP);
        1: req_bytes.push_back(CH_HT);
        default: begin
          put_str("\r\n");
          req_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_HT);
        end
      endcase
    end
  endfunction

  function automatic void build_random_request();
    int ulen;
    int sel;
    logic [7:0] c;
    string conn_name;
    conn_name = "connection:";
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      repeat ($urandom_range(1, 12)) req_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 1)) put_str("GET ");
    else put_str("HEAD ");
    sel = $urandom_range(0, 99);
    if (sel < 85) ulen = $urandom_range(0, 16);
    else if (sel < 95) ulen = $urandom_range(120, 127);
    else ulen = $urandom_range(128, 130);
    repeat (ulen) req_bytes.push_back(url_octet());
    put_str(" HTTP/1.1\r\n");
    repeat ($urandom_range(0, 4)) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        put_mixed("connection:");
        put_lws();
        if ($urandom_range(0, 1)) put_mixed("close");
        else put_mixed("keep-alive");
        put_lws();
        put_str("\r\n");
      end else if (sel == 4) begin
        put_mixed(conn_name.substr(0, $urandom_range(0, 9)));
        put_str("x: y\r\n");
      end else begin
        if ($urandom_range(0, 9) == 0) req_bytes.push_back(CH_SP);
        repeat ($urandom_range(1, 8)) req_bytes.push_back(8'($urandom_range("a", "z")));
        put_str(": ");
        repeat ($urandom_range(0, 10)) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_CR);
          req_bytes.push_back(c);
        end
        if ($urandom_range(0, 9) == 0) put_str("\r\n\tmore");
        put_str("\r\n");
      end
    end
    put_str("\r\n");
    sel = $urandom_range(0, 19);
    if (sel < 2) req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    else if (sel == 2) req_bytes = req_bytes[0:$urandom_range(0, req_bytes.size() - 1)];
  endfunction

  task automatic test_basic_requests();
    put_str("GET / HTTP/1.1\r\n\r\n");
    flush_request();
    put_str("HEAD ");
    req_bytes.push_back(8'h00);
    req_bytes.push_back(8'hFF);
    req_bytes.push_back(8'h7F);
    req_bytes.push_back(8'h80);
    req_bytes.push_back(8'h55);
    put_str(" HTTP/1.1\r\nCONNECTION:close\r\n\r\n");
    flush_request();
    put_str("GET /x HTTP/1.1\r\nConnection: \r\n\tKeep-Alive \r\n \t\r\n\r\n");
    flush_request();
    put_str("GET /y HTTP/1.1\r\n connection: close\r\nHost: a\r\n b\r\n");
    put_str("Connection:close\r\nconnection:\tkeep-alive\r\n\r\n");
    flush_request();
  endtask

  task automatic test_url_limits();
    put_str("GET  HTTP/1.1\r\n\r\n");
    flush_request();
    put_str("GET ");
    repeat (URL_DEPTH_DEFAULT - 1) req_bytes.push_back(url_octet());
    put_str(" HTTP/1.1\r\nConnection: close\r\n\r\n");
    flush_request();
    put_str("HEAD ");
    repeat (URL_DEPTH_DEFAULT) req_bytes.push_back(url_octet());
    flush_request();
  endtask

  task automatic test_syntax_errors();
    put_str("GETXHEAXPOSTget ");
    put_str("GET /a HTTP/1.0\r\n");
    put_str("GET /a HTTP/1.1\r\nHost: x\rY");
    put_str("GET /a HTTP/1.1\r\n\rX");
    put_str("GET /a HTTP/1.1\r\nConnection: closed\r\n");
    put_str("GET /a HTTP/1.1\r\nConnection:\r\nX");
    put_str("GET /a HTTP/1.1\r\nConnection:\r\rX");
    put_str("GET /a HTTP/1.1\r\nConnection: x");
    put_str("GET /a HTTP/1.1\r\nConnection: clo\r");
    put_str("GET /a HTTP/1.1\r\nConnection: close\rX");
    put_str("GET /a HTTP/1.1\r\nConnection: close x");
    put_str("GET /a HTTP/1.1\r\nX\r\r");
    flush_request();
  endtask

  task automatic test_backpressure();
    hold_req_cnt <= hold_req_cnt + 1;
    steady_send = 1'b1;
    put_str("HEAD /stall HTTP/1.1\r\nConnection: close\r\n\r\n");
    flush_request();
    steady_send = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_requests();
    int sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      build_random_request();
      sent += req_bytes.size();
      steady_send = ($urandom_range(0, 4) == 0);
      flush_request();
    end
    steady_send = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_requests();
    test_url_limits();
    test_syntax_errors();
    test_backpressure();
    test_random_requests();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && head_results_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/hrhp_pkg.sv
design/http_request_head_parser.sv
verif/tb_http_request_head_parser.sv
